// ----- design/atss_pkg.sv -----
package atss_pkg;

	typedef enum logic [2:0] {
		CMD_UPSERT   = 3'd0,
		CMD_REMOVE   = 3'd1,
		CMD_UPDATE   = 3'd2,
		CMD_SCHEDULE = 3'd3,
		CMD_HEALTH   = 3'd4,
		CMD_STATS    = 3'd5
	} cmd_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam logic [1:0] STRAT_WEIGHTED = 2'd0;
	localparam logic [1:0] STRAT_ROUND    = 2'd1;
	localparam logic [1:0] STRAT_SUCCESS  = 2'd2;
	localparam logic [1:0] STRAT_WEIGHT   = 2'd3;

	localparam logic [10:0] LOAD_ONE     = 11'd1024;
	localparam logic [10:0] HEALTH_LIMIT = 11'd972;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] agent_key;
		logic [10:0] load_level;
		logic [10:0] success_level;
		logic [15:0] weight_value;
		logic        available_in;
		logic [15:0] response_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        selected_valid;
		logic [31:0] selected_key;
		logic [8:0]  confidence;
		logic [15:0] estimated_ms;
		logic        healthy;
		logic [7:0]  entry_count;
		logic [31:0] tasks_scheduled;
		logic [31:0] tasks_placed;
	} out_item_t;

	// One stored worker entry.
	typedef struct packed {
		logic [31:0] key;
		logic [10:0] load;
		logic [10:0] success;
		logic [15:0] weight;
		logic        avail;
		logic [15:0] response;
	} entry_t;

endpackage

// ----- design/agent_table_score_selector.sv -----
// Worker table with weighted selection. Each command walks the table through
// one registered read port of the entry memory. An upsert, remove, update,
// health check or stats command reads and checks each stored entry in turn
// (S_RD, S_CHK), and a remove moves each entry behind the removed one down,
// reading it in S_SHIFT and writing it back in S_SHWR. A schedule reads and
// checks each entry and skips an unavailable one; an available one goes to
// S_CMP, in the weighted strategy by way of S_MUL, where one shared multiplier
// forms success * headroom and then that product times weight. After a
// schedule, a remove that finds its entry or an upsert that adds an entry, a
// 32-step modulo unit refreshes the round robin target. The table holds up to
// 128 entries by default. The block takes no new item while a command or the
// modulo unit is busy; a command's result waits in S_DONE until the output
// register is free, then waits in that register until taken, and the next
// item may be accepted meanwhile.
module agent_table_score_selector #(
	parameter int MAX_ENTRIES = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  atss_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output atss_pkg::out_item_t  out_data
);
	import atss_pkg::*;

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_RD    = 8'b0000_0010,
		S_CHK   = 8'b0000_0100,
		S_MUL   = 8'b0000_1000,
		S_CMP   = 8'b0001_0000,
		S_SHIFT = 8'b0010_0000,
		S_SHWR  = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [1:0] strat_q;
	in_item_t item_q;
	logic [CW-1:0] used_q;
	logic [31:0] tasks_q, placed_q;
	logic [CW-1:0] idx_q;
	logic [IW-1:0] rr_q;
	entry_t mem [MAX_ENTRIES];
	entry_t rd_q;
	logic [IW-1:0] rd_addr;
	logic [CW-1:0] pos_q;
	logic pos_found_q;
	logic found_q;
	logic [59:0] best_q;
	logic [IW-1:0] best_i_q;
	logic [31:0] best_key_q;
	logic [15:0] best_ms_q;
	logic [37:0] prod_q;
	logic unhealthy_q;
	logic out_valid_q;
	out_item_t out_q;

	// Memory: one write port, one registered read port.
	logic we;
	logic [IW-1:0] wa;
	entry_t wd;
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[rd_addr];
	end

	assign rd_addr = idx_q[IW-1:0];

	// Headroom of the entry being read.
	logic [10:0] head;
	assign head = (rd_q.load >= LOAD_ONE) ? 11'd0 : (LOAD_ONE - rd_q.load);

	// Shared multiplier: success * headroom, then product * weight.
	logic [21:0] mul_a;
	logic [15:0] mul_b;
	logic [37:0] mul_p;
	always_comb begin
		if (state_q == S_MUL) begin
			mul_a = prod_q[21:0];
			mul_b = rd_q.weight;
		end else begin
			mul_a = {11'd0, rd_q.success};
			mul_b = {5'd0, head};
		end
	end
	assign mul_p = mul_a * mul_b;

	logic [59:0] score;
	always_comb begin
		case (strat_q)
			STRAT_WEIGHTED: score = {22'd0, prod_q};
			STRAT_ROUND:    score = (rd_addr == rr_q) ? (60'd100 << 28) : 60'd0;
			STRAT_SUCCESS:  score = {30'd0, mul_p[21:0], 8'd0};
			default:        score = {24'd0, rd_q.weight, 20'd0};
		endcase
	end

	// Round robin target: task_counter mod used_count, refreshed by the
	// modulo unit below after every command that changes either.
	logic [31:0] mod_rem_q;
	logic mod_busy_q;
	logic start_mod;

	logic accept_in, out_free, last;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || mod_busy_q || start_mod;
	assign accept_in = in_valid && !in_stall;
	assign last = (idx_q + CW'(1)) >= used_q;

	// Memory write selection.
	always_comb begin
		we = 1'b0;
		wa = pos_q[IW-1:0];
		wd = '{key: item_q.agent_key, load: item_q.load_level,
			success: item_q.success_level, weight: item_q.weight_value,
			avail: item_q.available_in, response: item_q.response_ms};
		if (state_q == S_SHWR) begin
			we = 1'b1;
			wa = IW'(idx_q - CW'(1));
			wd = rd_q;
		end else if (state_q == S_DONE && out_free) begin
			if (item_q.cmd == CMD_UPSERT && used_q < CW'(MAX_ENTRIES)) begin
				we = 1'b1;
				wa = pos_found_q ? pos_q[IW-1:0] : used_q[IW-1:0];
			end else if (item_q.cmd == CMD_UPDATE && pos_found_q) begin
				we = 1'b1;
			end
		end
	end

	// Result of the finished command.
	out_item_t res;
	always_comb begin
		res = '0;
		case (item_q.cmd)
			CMD_UPSERT: if (used_q >= CW'(MAX_ENTRIES)) res.status = ST_FULL;
			CMD_REMOVE, CMD_UPDATE: if (!pos_found_q) res.status = ST_NOT_FOUND;
			CMD_SCHEDULE: begin
				if (found_q) begin
					res.selected_valid = 1'b1;
					res.selected_key = best_key_q;
					res.estimated_ms = best_ms_q;
					if (best_q == '0) res.confidence = 9'd128;
					else if (best_q >= (60'd1 << 28)) res.confidence = 9'd256;
					else res.confidence = {1'b0, best_q[27:20]};
				end
			end
			CMD_HEALTH: res.healthy = !unhealthy_q;
			default: ;
		endcase
	end

	// Commands that change the task counter or the entry count restart the
	// modulo unit.
	logic mod_kick;
	assign mod_kick = (state_q == S_DONE) && out_free &&
		((item_q.cmd == CMD_SCHEDULE) ||
		(item_q.cmd == CMD_UPSERT && used_q < CW'(MAX_ENTRIES) && !pos_found_q) ||
		(item_q.cmd == CMD_REMOVE && pos_found_q));

	// Modulo unit: restoring division of the task counter by used_count,
	// one bit per cycle, run after any change of either.
	logic [4:0] mod_bit_q;
	logic [32:0] mod_try;
	logic [31:0] mod_next;
	assign mod_try = {mod_rem_q, tasks_q[mod_bit_q]} - {{(33-CW){1'b0}}, used_q};
	assign mod_next = mod_try[32] ? {mod_rem_q[30:0], tasks_q[mod_bit_q]} : mod_try[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_busy_q <= 1'b0;
			mod_bit_q <= '0;
			mod_rem_q <= '0;
			rr_q <= '0;
		end else if (start_mod) begin
			mod_busy_q <= 1'b1;
			mod_bit_q <= 5'd31;
			mod_rem_q <= '0;
		end else if (mod_busy_q) begin
			mod_rem_q <= mod_next;
			if (mod_bit_q == 5'd0) begin
				mod_busy_q <= 1'b0;
				rr_q <= mod_next[IW-1:0];
			end
			mod_bit_q <= mod_bit_q - 5'd1;
		end
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			strat_q <= STRAT_WEIGHTED;
			used_q <= '0;
			tasks_q <= '0;
			placed_q <= '0;
			out_valid_q <= 1'b0;
			idx_q <= '0;
			start_mod <= 1'b0;
			found_q <= 1'b0;
		end else begin
			start_mod <= mod_kick;
			if (cfg_we) strat_q <= cfg_wdata;
			out_valid_q <= (state_q == S_DONE && out_free) || (out_valid_q && out_stall);
			case (state_q)
				S_IDLE: begin
					if (accept_in) begin
						item_q <= in_data;
						idx_q <= '0;
						pos_found_q <= 1'b0;
						found_q <= 1'b0;
						unhealthy_q <= 1'b0;
						best_q <= '0;
						best_i_q <= '0;
						state_q <= (used_q == '0) ? S_DONE : S_RD;
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (item_q.cmd == CMD_SCHEDULE) begin
						prod_q <= {16'd0, mul_p[21:0]};
						if (!rd_q.avail) begin
							state_q <= last ? S_DONE : S_RD;
							idx_q <= idx_q + CW'(1);
						end else if (strat_q == STRAT_WEIGHTED) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_CMP;
						end
					end else begin
						if (rd_q.load > HEALTH_LIMIT) unhealthy_q <= 1'b1;
						if (!pos_found_q && rd_q.key == item_q.agent_key) begin
							pos_found_q <= 1'b1;
							pos_q <= idx_q;
						end
						if (item_q.cmd == CMD_REMOVE && !pos_found_q &&
							rd_q.key == item_q.agent_key) begin
							state_q <= last ? S_DONE : S_SHIFT;
							idx_q <= idx_q + CW'(1);
						end else begin
							state_q <= last ? S_DONE : S_RD;
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				S_MUL, S_CMP: begin
					if (state_q == S_MUL) begin
						state_q <= S_CMP;
						prod_q <= mul_p;
					end else begin
						if (!found_q || score > best_q) begin
							found_q <= 1'b1;
							best_q <= score;
							best_i_q <= rd_addr;
							best_key_q <= rd_q.key;
							best_ms_q <= rd_q.response;
						end
						state_q <= last ? S_DONE : S_RD;
						idx_q <= idx_q + CW'(1);
					end
				end
				S_SHIFT: state_q <= S_SHWR;
				S_SHWR: begin
					state_q <= last ? S_DONE : S_SHIFT;
					idx_q <= idx_q + CW'(1);
				end
				S_DONE: begin
					if (out_free) begin
						out_q <= res;
						state_q <= S_IDLE;
						case (item_q.cmd)
							CMD_UPSERT: begin
								if (used_q < CW'(MAX_ENTRIES) && !pos_found_q)
									used_q <= used_q + CW'(1);
							end
							CMD_REMOVE: if (pos_found_q) used_q <= used_q - CW'(1);
							CMD_SCHEDULE: begin
								tasks_q <= tasks_q + 32'd1;
								if (found_q) placed_q <= placed_q + 32'd1;
							end
							default: ;
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Counters in the result reflect the state after the command.
	always_comb begin
		out_data = out_q;
		out_data.entry_count = 8'(used_q);
		out_data.tasks_scheduled = tasks_q;
		out_data.tasks_placed = placed_q;
	end
	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(MAX_ENTRIES)) else $error("entry count out of range");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall) else $error("accepted while busy");
	a_no_pick_conf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.selected_valid |-> out_q.confidence == 9'd0)
		else $error("confidence without selection");
	a_best_idx: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> CW'(best_i_q) < used_q) else $error("best index beyond table");
`endif

endmodule
